FILE: src/gyr_pkg.sv
// ----------------------------------------------------------------------------
// gyr_pkg
// shared types, widths and cordic constants for the gimbal rotation unit
// ----------------------------------------------------------------------------
package gyr_pkg;

    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int CORDIC_ITERS       = 28;
    localparam int CORDIC_FRAC        = 30;
    localparam int XY_W               = 34;
    localparam int Z_W                = 36;
    localparam int ANG_W              = 17;
    localparam int PT_W               = 32;
    localparam int FULL_TURN          = 36000;
    localparam int QUARTER_TURN       = FULL_TURN / 4;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [XY_W-1:0] t_xy;
    typedef logic signed [Z_W-1:0]  t_z;
    typedef logic signed [PT_W-1:0] t_pt;

    typedef struct packed {
        t_xy        x;
        t_xy        y;
        t_z         z;
        logic [1:0] quad;
    } t_lane;

    typedef struct packed {
        logic  valid;
        logic  opcode;
        t_pt   px;
        t_pt   py;
        t_pt   pz;
        t_lane pitch;
        t_lane yaw;
    } t_cell_data;

    // arctangent of 2^-i in units of 1e-8 degree
    function automatic t_z atan_val(input int idx);
        case (idx)
            0:       return 36'sd4500000000;
            1:       return 36'sd2656505118;
            2:       return 36'sd1403624347;
            3:       return 36'sd712501635;
            4:       return 36'sd357633437;
            5:       return 36'sd178991061;
            6:       return 36'sd89517371;
            7:       return 36'sd44761417;
            8:       return 36'sd22381050;
            9:       return 36'sd11190568;
            10:      return 36'sd5595289;
            11:      return 36'sd2797645;
            12:      return 36'sd1398823;
            13:      return 36'sd699411;
            14:      return 36'sd349706;
            15:      return 36'sd174853;
            16:      return 36'sd87426;
            17:      return 36'sd43713;
            18:      return 36'sd21857;
            19:      return 36'sd10928;
            20:      return 36'sd5464;
            21:      return 36'sd2732;
            22:      return 36'sd1366;
            23:      return 36'sd683;
            24:      return 36'sd342;
            25:      return 36'sd171;
            26:      return 36'sd85;
            27:      return 36'sd43;
            default: return '0;
        endcase
    endfunction

endpackage

FILE: src/gimbal_yaw_pitch_rotation_unit.sv
// ----------------------------------------------------------------------------
// gimbal_yaw_pitch_rotation_unit
// rotates a Q16.16 point by gimbal pitch and yaw, forward or inverse
// ----------------------------------------------------------------------------
// usage:
//   a request is taken on each rising edge with start high and busy low; busy
//   is always low, so one point can be issued every cycle.
//   the request carries opcode (0 gimbal to absolute, 1 the inverse), the
//   point and the two angles in hundredths of a degree; any angle wraps.
//   the pipe runs angle wrap and scaling, then 28 cordic cells (one
//   micro-rotation per cell, both angles side by side), then trig rounding,
//   coefficient products, coefficient rounding, point products and the final sum.
//   throughput is one point per cycle, set by the cell row.
//   each result shows on the o_ ports for exactly one cycle with o_valid
//   high; o_saturated flags a clipped component. the receiver cannot stall,
//   so results must be taken on that cycle.
//   reset clears all valid flags in the pipe; points in flight are dropped.
// ----------------------------------------------------------------------------
module gimbal_yaw_pitch_rotation_unit #(
    parameter int TRIG_FRAC_BITS = gyr_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_opcode,
    input  logic signed [gyr_pkg::PT_W-1:0]  i_x_in,
    input  logic signed [gyr_pkg::PT_W-1:0]  i_y_in,
    input  logic signed [gyr_pkg::PT_W-1:0]  i_z_in,
    input  logic signed [gyr_pkg::ANG_W-1:0] i_pitch_angle,
    input  logic signed [gyr_pkg::ANG_W-1:0] i_yaw_angle,
    output logic                             o_valid,
    output logic signed [gyr_pkg::PT_W-1:0]  o_x_out,
    output logic signed [gyr_pkg::PT_W-1:0]  o_y_out,
    output logic signed [gyr_pkg::PT_W-1:0]  o_z_out,
    output logic                             o_saturated
);
    import gyr_pkg::*;

    logic [1:0] r_valid;
    logic [1:0] r_opcode;
    t_pt        r_px [2];
    t_pt        r_py [2];
    t_pt        r_pz [2];
    logic [1:0] w_pquad;
    logic [1:0] w_yquad;
    t_z         w_pz;
    t_z         w_yz;
    t_cell_data w_chain [CORDIC_ITERS+1];

    assign busy = 1'b0;

    gyr_angle_prep u_pitch_prep (
        .i_clk   (i_clk),
        .i_angle (i_pitch_angle),
        .o_quad  (w_pquad),
        .o_z     (w_pz)
    );

    gyr_angle_prep u_yaw_prep (
        .i_clk   (i_clk),
        .i_angle (i_yaw_angle),
        .o_quad  (w_yquad),
        .o_z     (w_yz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[0], start & ~busy};
        end
        r_opcode <= {r_opcode[0], i_opcode};
        r_px[0]  <= i_x_in;
        r_py[0]  <= i_y_in;
        r_pz[0]  <= i_z_in;
        r_px[1]  <= r_px[0];
        r_py[1]  <= r_py[0];
        r_pz[1]  <= r_pz[0];
    end

    always_comb begin
        w_chain[0].valid      = r_valid[1];
        w_chain[0].opcode     = r_opcode[1];
        w_chain[0].px         = r_px[1];
        w_chain[0].py         = r_py[1];
        w_chain[0].pz         = r_pz[1];
        w_chain[0].pitch.x    = CORDIC_GAIN;
        w_chain[0].pitch.y    = '0;
        w_chain[0].pitch.z    = w_pz;
        w_chain[0].pitch.quad = w_pquad;
        w_chain[0].yaw.x      = CORDIC_GAIN;
        w_chain[0].yaw.y      = '0;
        w_chain[0].yaw.z      = w_yz;
        w_chain[0].yaw.quad   = w_yquad;
    end

    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cell
        gyr_cordic_cell #(
            .SHIFT (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_data  (w_chain[g]),
            .o_data  (w_chain[g+1])
        );
    end

    gyr_matrix #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (w_chain[CORDIC_ITERS]),
        .o_valid (o_valid),
        .o_x     (o_x_out),
        .o_y     (o_y_out),
        .o_z     (o_z_out),
        .o_sat   (o_saturated)
    );

`ifndef SYNTHESIS
    a_sat_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> o_valid)
        else $error("saturation flag without result");

    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> (o_x_out == 32'sh7FFFFFFF || o_x_out == 32'sh80000000 ||
                         o_y_out == 32'sh7FFFFFFF || o_y_out == 32'sh80000000 ||
                         o_z_out == 32'sh7FFFFFFF || o_z_out == 32'sh80000000))
        else $error("saturation flagged but no component at a bound");

    a_pipe_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_valid[0])
        else $error("accepted request not entered into pipe");
`endif

endmodule

FILE: src/gyr_angle_prep.sv
// ----------------------------------------------------------------------------
// gyr_angle_prep
// wraps an angle into one turn, splits quadrant and scales remainder for cordic
// ----------------------------------------------------------------------------
module gyr_angle_prep (
    input  logic                             i_clk,
    input  logic signed [gyr_pkg::ANG_W-1:0] i_angle,
    output logic [1:0]                       o_quad,
    output gyr_pkg::t_z                      o_z
);
    import gyr_pkg::*;

    logic signed [18:0] w_sum;
    logic [17:0]        w_v;
    logic [15:0]        w_red;
    logic [1:0]         w_quad;
    logic [13:0]        w_rem;
    logic [1:0]         r_quad1;
    logic [13:0]        r_rem;

    always_comb begin
        // offset by two turns so the value is positive, then strip whole turns
        w_sum = 19'(i_angle) + 19'sd72000;
        w_v   = w_sum[17:0];
        if (w_v >= 18'd108000) begin
            w_red = 16'(w_v - 18'd108000);
        end else if (w_v >= 18'd72000) begin
            w_red = 16'(w_v - 18'd72000);
        end else if (w_v >= 18'd36000) begin
            w_red = 16'(w_v - 18'd36000);
        end else begin
            w_red = w_v[15:0];
        end
        if (w_red >= 16'd27000) begin
            w_quad = 2'd3;
            w_rem  = 14'(w_red - 16'd27000);
        end else if (w_red >= 16'd18000) begin
            w_quad = 2'd2;
            w_rem  = 14'(w_red - 16'd18000);
        end else if (w_red >= 16'(QUARTER_TURN)) begin
            w_quad = 2'd1;
            w_rem  = 14'(w_red - 16'(QUARTER_TURN));
        end else begin
            w_quad = 2'd0;
            w_rem  = w_red[13:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_quad1 <= w_quad;
        r_rem   <= w_rem;
        o_quad  <= r_quad1;
        o_z     <= t_z'({22'd0, r_rem}) * 36'sd1000000;
    end

endmodule

FILE: src/gyr_cordic_cell.sv
// ----------------------------------------------------------------------------
// gyr_cordic_cell
// one cordic micro-rotation for the pitch and yaw lanes, registered
// ----------------------------------------------------------------------------
module gyr_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gyr_pkg::t_cell_data i_data,
    output gyr_pkg::t_cell_data o_data
);
    import gyr_pkg::*;

    t_cell_data n_data;
    t_cell_data r_data;

    function automatic t_lane rot(input t_lane l);
        t_lane r;
        t_xy   xs;
        t_xy   ys;
        xs = l.x >>> SHIFT;
        ys = l.y >>> SHIFT;
        r  = l;
        if (!l.z[Z_W-1]) begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - atan_val(SHIFT);
        end else begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + atan_val(SHIFT);
        end
        return r;
    endfunction

    always_comb begin
        n_data       = i_data;
        n_data.pitch = rot(i_data.pitch);
        n_data.yaw   = rot(i_data.yaw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: src/gyr_matrix.sv
// ----------------------------------------------------------------------------
// gyr_matrix
// trig rounding, coefficient products and the rounded, saturated dot products
// ----------------------------------------------------------------------------
module gyr_matrix #(
    parameter int TRIG_FRAC_BITS = gyr_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gyr_pkg::t_cell_data             i_data,
    output logic                            o_valid,
    output logic signed [gyr_pkg::PT_W-1:0] o_x,
    output logic signed [gyr_pkg::PT_W-1:0] o_y,
    output logic signed [gyr_pkg::PT_W-1:0] o_z,
    output logic                            o_sat
);
    import gyr_pkg::*;

    localparam int TW  = TRIG_FRAC_BITS + 1;
    localparam int PW  = 2 * TW;
    localparam int CW  = TRIG_FRAC_BITS + 2;
    localparam int PRW = PT_W + CW;
    localparam int AW  = PRW + 2;
    localparam int RSH = CORDIC_FRAC - TRIG_FRAC_BITS;

    typedef logic signed [TW-1:0]  t_trig;
    typedef logic signed [PW-1:0]  t_prod;
    typedef logic signed [CW-1:0]  t_coef;
    typedef logic signed [PRW-1:0] t_term;
    typedef logic signed [AW-1:0]  t_acc;

    function automatic t_trig to_trig(input t_xy q);
        logic signed [XY_W:0] t;
        logic signed [XY_W:0] lim;
        lim = (XY_W+1)'((64'sd1 <<< TRIG_FRAC_BITS) - 64'sd1);
        t   = ((XY_W+1)'(q) + ((XY_W+1)'(1) <<< (RSH - 1))) >>> RSH;
        if (t > lim) begin
            t = lim;
        end
        if (t < -lim) begin
            t = -lim;
        end
        return TW'(t);
    endfunction

    function automatic t_coef rnd(input t_prod p);
        logic signed [PW:0] t;
        t = ((PW+1)'(p) + ((PW+1)'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
        return CW'(t);
    endfunction

    // sin/cos of one lane after quadrant folding
    function automatic logic [2*TW-1:0] fold(input t_lane l);
        t_trig sv;
        t_trig cv;
        t_trig s;
        t_trig c;
        sv = to_trig(l.y);
        cv = to_trig(l.x);
        case (l.quad)
            2'd0:    begin s = sv;  c = cv;  end
            2'd1:    begin s = cv;  c = -sv; end
            2'd2:    begin s = -sv; c = -cv; end
            default: begin s = -cv; c = sv;  end
        endcase
        return {s, c};
    endfunction

    logic [2:0] r_valid;
    logic [1:0] r_opcode;
    t_pt        r_pt [3][3];

    t_trig r1_sp, r1_cp, r1_sy, r1_cy;
    t_trig r2_sp, r2_cp, r2_sy, r2_cy;
    t_prod r2_ss, r2_cs, r2_sc, r2_cc;
    t_coef n_e [3][3];
    t_coef r3_e [3][3];
    t_term r4_t [3][3];
    logic  r4_valid;
    t_acc  w_acc [3];
    t_acc  w_rnd [3];
    t_pt   w_out [3];
    logic  w_sat;

    always_ff @(posedge i_clk) begin
        {r1_sp, r1_cp} <= fold(i_data.pitch);
        {r1_sy, r1_cy} <= fold(i_data.yaw);
        r2_sp <= r1_sp;
        r2_cp <= r1_cp;
        r2_sy <= r1_sy;
        r2_cy <= r1_cy;
        r2_ss <= PW'(r1_sp * r1_sy);
        r2_cs <= PW'(r1_cp * r1_sy);
        r2_sc <= PW'(r1_sp * r1_cy);
        r2_cc <= PW'(r1_cp * r1_cy);
        r_pt[0] <= '{i_data.px, i_data.py, i_data.pz};
        r_pt[1] <= r_pt[0];
        r_pt[2] <= r_pt[1];
        r_opcode <= {r_opcode[0], i_data.opcode};
    end

    always_comb begin
        t_coef m [3][3];
        m[0][0] = CW'(r2_cy);
        m[0][1] = rnd(r2_ss);
        m[0][2] = -rnd(r2_cs);
        m[1][0] = '0;
        m[1][1] = CW'(r2_cp);
        m[1][2] = CW'(r2_sp);
        m[2][0] = CW'(r2_sy);
        m[2][1] = -rnd(r2_sc);
        m[2][2] = rnd(r2_cc);
        // inverse uses the transpose
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_e[i][j] = r_opcode[1] ? m[j][i] : m[i][j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_e <= n_e;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r4_t[i][j] <= PRW'(r_pt[2][j] * r3_e[i][j]);
            end
        end
    end

    always_comb begin
        w_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_acc[i] = AW'(r4_t[i][0]) + AW'(r4_t[i][1]) + AW'(r4_t[i][2]);
            w_rnd[i] = (w_acc[i] + (AW'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
            if (w_rnd[i] > AW'(64'sh7FFFFFFF)) begin
                w_out[i] = 32'sh7FFFFFFF;
                w_sat    = 1'b1;
            end else if (w_rnd[i] < -AW'(64'sh80000000)) begin
                w_out[i] = 32'sh80000000;
                w_sat    = 1'b1;
            end else begin
                w_out[i] = PT_W'(w_rnd[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r4_valid <= 1'b0;
            o_valid  <= 1'b0;
            o_sat    <= 1'b0;
        end else begin
            r_valid  <= {r_valid[1:0], i_data.valid};
            r4_valid <= r_valid[2];
            o_valid  <= r4_valid;
            o_sat    <= r4_valid & w_sat;
        end
        o_x <= w_out[0];
        o_y <= w_out[1];
        o_z <= w_out[2];
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks gimbal_yaw_pitch_rotation_unit against a bit-exact rotation predictor
// (cordic trig, rounded coefficients, saturated dot products), directed corner
// points first, then random points with random idle gaps on the request side
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic        opcode;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [16:0] pitch;
        logic [16:0] yaw;
    } t_point_req;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        sat;
    } t_rotated;

    localparam int TRIG_BITS = gyr_pkg::TRIG_FRAC_BITS_DEF;
    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    localparam longint ARCTAN_E8 [28] = '{
        64'sd4500000000, 64'sd2656505118, 1403624347, 712501635, 357633437,
        178991061, 89517371, 44761417, 22381050, 11190568,
        5595289, 2797645, 1398823, 699411, 349706, 174853,
        87426, 43713, 21857, 10928, 5464, 2732, 1366, 683,
        342, 171, 85, 43
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_opcode;
    logic signed [31:0] i_x_in, i_y_in, i_z_in;
    logic signed [16:0] i_pitch_angle, i_yaw_angle;
    logic               o_valid;
    logic signed [31:0] o_x_out, o_y_out, o_z_out;
    logic               o_saturated;

    t_point_req pending_points[$];
    t_rotated   expected_points[$];
    t_point_req cur_req;
    int         issued;
    int         mismatches;
    bit         stim_done;
    bit         drained_once;

    gimbal_yaw_pitch_rotation_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_x_in(i_x_in), .i_y_in(i_y_in), .i_z_in(i_z_in),
        .i_pitch_angle(i_pitch_angle), .i_yaw_angle(i_yaw_angle),
        .o_valid(o_valid), .o_x_out(o_x_out), .o_y_out(o_y_out),
        .o_z_out(o_z_out), .o_saturated(o_saturated)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_trig(longint q30);
        longint lim;
        longint v;
        lim = (longint'(1) <<< TRIG_BITS) - 1;
        v = round_shift(q30, 30 - TRIG_BITS);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic void sin_cos(input logic [16:0] raw, output longint s,
                                    output longint c);
        longint a, r, cx, cy, cz, xs, ys, sv, cv;
        int quad;
        a = longint'($signed(raw)) % 36000;
        if (a < 0) a += 36000;
        quad = int'(a / 9000);
        r = a % 9000;
        cx = 652032874;
        cy = 0;
        cz = r * 1000000;
        for (int i = 0; i < 28; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cz >= 0) begin
                cx -= ys; cy += xs; cz -= ARCTAN_E8[i];
            end else begin
                cx += ys; cy -= xs; cz += ARCTAN_E8[i];
            end
        end
        sv = clamp_trig(cy);
        cv = clamp_trig(cx);
        case (quad)
            0: begin s = sv;  c = cv;  end
            1: begin s = cv;  c = -sv; end
            2: begin s = -sv; c = -cv; end
            default: begin s = -cv; c = sv; end
        endcase
    endfunction

    function automatic logic [31:0] saturate_out(longint acc, inout logic sat);
        longint v;
        v = round_shift(acc, TRIG_BITS);
        if (v > 64'sd2147483647) begin v = 64'sd2147483647; sat = 1'b1; end
        if (v < -64'sd2147483648) begin v = -64'sd2147483648; sat = 1'b1; end
        return v[31:0];
    endfunction

    function automatic t_rotated rotate_point(t_point_req rq);
        longint sp, cp, sy, cy, acc;
        longint p[3];
        longint m[3][3];
        logic [31:0] res[3];
        logic sat;
        t_rotated rot;
        sat = 1'b0;
        p[0] = longint'($signed(rq.x));
        p[1] = longint'($signed(rq.y));
        p[2] = longint'($signed(rq.z));
        sin_cos(rq.pitch, sp, cp);
        sin_cos(rq.yaw, sy, cy);
        m[0][0] = cy; m[0][1] = round_shift(sp * sy, TRIG_BITS);
        m[0][2] = -round_shift(cp * sy, TRIG_BITS);
        m[1][0] = 0;  m[1][1] = cp; m[1][2] = sp;
        m[2][0] = sy; m[2][1] = -round_shift(sp * cy, TRIG_BITS);
        m[2][2] = round_shift(cp * cy, TRIG_BITS);
        for (int i = 0; i < 3; i++) begin
            if (rq.opcode == OP_INVERSE)
                acc = p[0] * m[0][i] + p[1] * m[1][i] + p[2] * m[2][i];
            else
                acc = p[0] * m[i][0] + p[1] * m[i][1] + p[2] * m[i][2];
            res[i] = saturate_out(acc, sat);
        end
        rot.x = res[0]; rot.y = res[1]; rot.z = res[2]; rot.sat = sat;
        return rot;
    endfunction

    task automatic add_point(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [16:0] pitch, logic [16:0] yaw);
        t_point_req rq;
        rq.opcode = op; rq.x = x; rq.y = y; rq.z = z; rq.pitch = pitch; rq.yaw = yaw;
        pending_points = {pending_points, rq};
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 99)
                                           : 32'h80000000 + $urandom_range(0, 99);
            default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
        endcase
    endfunction

    function automatic logic [16:0] rand_angle();
        case ($urandom_range(0, 4))
            0: return 17'($urandom);
            1: return 17'(9000 * $urandom_range(0, 8) - 36000 + $urandom_range(0, 2) - 1);
            default: return 17'($signed($urandom_range(0, 72000)) - 36000);
        endcase
    endfunction

    initial begin
        logic [16:0] angs[10];
        angs = '{17'd0, 17'd9000, 17'd18000, 17'd27000, 17'd4500,
                 17'h1ffff & -17'sd36000, 17'd36000, 17'h0ffff, 17'h10000,
                 17'h1ffff & -17'sd9000};
        // extremes of the point and the angle fields, both directions
        for (int i = 0; i < 10; i++)
            add_point(i[0] ? OP_INVERSE : OP_FORWARD, 32'h7fffffff, 32'h80000000,
                      32'h00010000, angs[i], angs[9 - i]);
        add_point(OP_FORWARD, 32'h0, 32'h0, 32'h0, 17'd0, 17'd0);
        add_point(OP_INVERSE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 17'h1ffff, 17'h1ffff);
        // sum of two full-scale components overflows at 45 degrees
        add_point(OP_FORWARD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 17'd4500, 17'd4500);
        add_point(OP_INVERSE, 32'h80000000, 32'h80000000, 32'h80000000, 17'd4500, 17'd4500);
        add_point(OP_FORWARD, 32'h80000000, 32'h7fffffff, 32'h80000000, 17'd13500, 17'd31500);
        add_point(OP_INVERSE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 17'd22500, 17'd22500);
        add_point(OP_FORWARD, 32'h00010000, 32'h00020000, 32'h00030000, 17'd3000, 17'd6000);
        add_point(OP_INVERSE, 32'h00010000, 32'h00020000, 32'h00030000, 17'd3000, 17'd6000);
        add_point(OP_FORWARD, 32'h55555555, 32'haaaaaaaa, 32'h5a5a5a5a, 17'h15555, 17'h0aaaa);
        add_point(OP_INVERSE, 32'haaaaaaaa, 32'h55555555, 32'ha5a5a5a5, 17'h0aaaa, 17'h15555);
        for (int i = 0; i < 900; i++)
            add_point(1'($urandom), rand_coord(), rand_coord(), rand_coord(),
                      rand_angle(), rand_angle());
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // request driver
    always @(posedge i_clk) begin
        bit idle;
        if (i_rst_n !== 1'b1) begin
            start <= 1'b0;
            i_opcode <= 1'b0;
            i_x_in <= '0; i_y_in <= '0; i_z_in <= '0;
            i_pitch_angle <= '0; i_yaw_angle <= '0;
            issued = 0;
            stim_done = 1'b0;
            drained_once = 1'b0;
        end else begin
            if (start && !busy) begin
                expected_points = {expected_points, rotate_point(cur_req)};
                issued++;
            end
            if (!(start && busy)) begin
                idle = ($urandom_range(0, 99) < 12) && !(issued >= 300 && issued < 550);
                // one pause that lets the pipe run dry
                if (issued == 450 && !drained_once) begin
                    idle = 1'b1;
                    if (expected_points.size() == 0) drained_once = 1'b1;
                end
                if (!idle && pending_points.size() > 0) begin
                    cur_req = pending_points.pop_front();
                    start <= 1'b1;
                    i_opcode <= cur_req.opcode;
                    i_x_in <= cur_req.x; i_y_in <= cur_req.y; i_z_in <= cur_req.z;
                    i_pitch_angle <= cur_req.pitch; i_yaw_angle <= cur_req.yaw;
                end else begin
                    start <= 1'b0;
                    if (pending_points.size() == 0 && !(start && busy)) stim_done = 1'b1;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_rotated want;
        if (i_rst_n && o_valid) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h z=%h sat=%b",
                             o_x_out, o_y_out, o_z_out, o_saturated);
            end else begin
                want = expected_points.pop_front();
                if (o_x_out !== want.x || o_y_out !== want.y || o_z_out !== want.z ||
                    o_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%h y=%h z=%h sat=%b got x=%h y=%h z=%h sat=%b",
                                 want.x, want.y, want.z, want.sat,
                                 o_x_out, o_y_out, o_z_out, o_saturated);
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        wait (i_rst_n === 1'b1);
        wait (stim_done && expected_points.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
